@@ hw/rtl/igtg_pkg.sv @@
package igtg_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INTEG,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic integ;
    logic mul;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [15:0] q;
  } rd_t;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [2:0] RSN_NONE  = 3'd0;
  localparam logic [2:0] RSN_LIFT  = 3'd1;
  localparam logic [2:0] RSN_PITCH = 3'd2;
  localparam logic [2:0] RSN_ROLL  = 3'd3;
  localparam logic [2:0] RSN_YAW   = 3'd4;

  localparam logic [2:0] CFG_BIAS_X       = 3'd0;
  localparam logic [2:0] CFG_BIAS_Y       = 3'd1;
  localparam logic [2:0] CFG_BIAS_Z       = 3'd2;
  localparam logic [2:0] CFG_ACCEL_WEIGHT = 3'd3;
  localparam logic [2:0] CFG_RATE_WEIGHT  = 3'd4;
  localparam logic [2:0] CFG_SAMPLE_PER   = 3'd5;
  localparam logic [2:0] CFG_INT_LIMIT    = 3'd6;
  localparam logic [2:0] CFG_LIFT_THR     = 3'd7;

  localparam logic signed [15:0] RST_BIAS_X       = -16'sd2;
  localparam logic signed [15:0] RST_BIAS_Y       = 16'sd2;
  localparam logic signed [15:0] RST_BIAS_Z       = 16'sd0;
  localparam logic [7:0]         RST_ACCEL_WEIGHT = 8'd4;
  localparam logic [7:0]         RST_RATE_WEIGHT  = 8'd4;
  localparam logic [15:0]        RST_SAMPLE_PER   = 16'd328;
  localparam logic [30:0]        RST_INT_LIMIT    = 31'd20000;
  localparam logic [15:0]        RST_LIFT_THR     = 16'd8000;

  localparam logic signed [16:0] DEADBAND = 17'sd5;

  // reciprocal multiply, exact below the saturation point
  localparam logic signed [31:0] PR_SAT_POS  = 32'sd32768000;
  localparam logic signed [31:0] PR_SAT_NEG  = -32'sd32768000;
  localparam logic [25:0]        PR_RECIP    = 26'd34359739;
  localparam int                 PR_SHIFT    = 35;
  localparam logic signed [31:0] YAW_SAT_POS = 32'sd983040000;
  localparam logic signed [31:0] YAW_SAT_NEG = -32'sd983040000;
  localparam logic [30:0]        YAW_RECIP   = 31'd1172812403;
  localparam int                 YAW_SHIFT   = 45;

endpackage

@@ hw/rtl/igtg_ctrl.sv @@
module igtg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output igtg_pkg::cmd_t    cmd
);

  igtg_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= igtg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      igtg_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = igtg_pkg::ST_INTEG;
        end
      end
      igtg_pkg::ST_INTEG: begin
        cmd.integ = 1'b1;
        state_nxt = igtg_pkg::ST_MUL;
      end
      igtg_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = igtg_pkg::ST_FIN;
      end
      igtg_pkg::ST_FIN: begin
        // hold while the previous result is still waiting
        if (!out_valid_r || out_tready) begin
          cmd.fin   = 1'b1;
          state_nxt = igtg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = igtg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == igtg_pkg::ST_INTEG)
    else $error("accepted item did not start integration");

  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_tvalid)
    else $error("finished item not presented");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == igtg_pkg::ST_FIN && out_valid_r && !out_tready)
      |=> state_r == igtg_pkg::ST_FIN)
    else $error("result overwritten while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == igtg_pkg::ST_MUL) |-> !cmd.load && !cmd.fin)
    else $error("commands overlap during multiply step");

endmodule

@@ hw/rtl/igtg_dp.sv @@
module igtg_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  igtg_pkg::cmd_t    cmd,
  input  logic              cfg_wr,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_tuser,
  input  logic [79:0]       in_tdata,
  output logic [87:0]       out_tdata
);

  logic signed [15:0] bias_x_r, bias_y_r, bias_z_r;
  logic [7:0]         accel_weight_r, rate_weight_r;
  logic [15:0]        sample_period_r, lift_threshold_r;
  logic [30:0]        integral_limit_r;

  logic signed [31:0] pitch_sum_r, roll_sum_r, yaw_sum_r, angle_r;
  logic signed [15:0] prev_az_r;

  logic               clr_r;
  logic signed [16:0] rx_r, ry_r, rz_r;
  logic signed [15:0] ax_r, az_r;
  logic               lift_r;
  logic signed [26:0] p1_r;
  logic signed [41:0] p2_r;
  logic signed [60:0] prod_r;
  igtg_pkg::rd_t      rd_p_r, rd_r_r, rd_y_r;
  logic [87:0]        out_r;

  function automatic logic signed [16:0] dband(input logic signed [15:0] r,
                                               input logic signed [15:0] b);
    logic signed [16:0] s;
    s = {r[15], r} + {b[15], b};
    return (s <= igtg_pkg::DEADBAND && s >= -igtg_pkg::DEADBAND) ? 17'sd0 : s;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [16:0] r);
    logic signed [32:0] t;
    t = {a[31], a} + {{16{r[16]}}, r};
    if (t[32] != t[31]) return t[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return t[31:0];
  endfunction

  function automatic logic [32:0] mag33(input logic signed [31:0] s);
    logic [32:0] e;
    e = {s[31], s};
    return s[31] ? (~e + 33'd1) : e;
  endfunction

  function automatic igtg_pkg::rd_t div_pr(input logic signed [31:0] s);
    igtg_pkg::rd_t r;
    logic [32:0]   n;
    logic [50:0]   m;
    n     = mag33(s);
    m     = 51'(n[24:0]) * 51'(igtg_pkg::PR_RECIP);
    r.neg = s[31];
    r.sat = (s >= igtg_pkg::PR_SAT_POS) || (s <= igtg_pkg::PR_SAT_NEG);
    r.q   = m[igtg_pkg::PR_SHIFT +: 16];
    return r;
  endfunction

  function automatic igtg_pkg::rd_t div_yaw(input logic signed [31:0] s);
    igtg_pkg::rd_t r;
    logic [32:0]   n;
    logic [60:0]   m;
    n     = mag33(s);
    m     = 61'(n[29:0]) * 61'(igtg_pkg::YAW_RECIP);
    r.neg = s[31];
    r.sat = (s >= igtg_pkg::YAW_SAT_POS) || (s <= igtg_pkg::YAW_SAT_NEG);
    r.q   = m[igtg_pkg::YAW_SHIFT +: 16];
    return r;
  endfunction

  function automatic logic [15:0] readout(input igtg_pkg::rd_t r);
    if (r.sat) return r.neg ? 16'h8000 : 16'h7FFF;
    return r.neg ? (~r.q + 16'd1) : r.q;
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_x_r         <= igtg_pkg::RST_BIAS_X;
      bias_y_r         <= igtg_pkg::RST_BIAS_Y;
      bias_z_r         <= igtg_pkg::RST_BIAS_Z;
      accel_weight_r   <= igtg_pkg::RST_ACCEL_WEIGHT;
      rate_weight_r    <= igtg_pkg::RST_RATE_WEIGHT;
      sample_period_r  <= igtg_pkg::RST_SAMPLE_PER;
      integral_limit_r <= igtg_pkg::RST_INT_LIMIT;
      lift_threshold_r <= igtg_pkg::RST_LIFT_THR;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        igtg_pkg::CFG_BIAS_X:       bias_x_r         <= cfg_data[15:0];
        igtg_pkg::CFG_BIAS_Y:       bias_y_r         <= cfg_data[15:0];
        igtg_pkg::CFG_BIAS_Z:       bias_z_r         <= cfg_data[15:0];
        igtg_pkg::CFG_ACCEL_WEIGHT: accel_weight_r   <= cfg_data[7:0];
        igtg_pkg::CFG_RATE_WEIGHT:  rate_weight_r    <= cfg_data[7:0];
        igtg_pkg::CFG_SAMPLE_PER:   sample_period_r  <= cfg_data[15:0];
        igtg_pkg::CFG_INT_LIMIT:    integral_limit_r <= cfg_data[30:0];
        igtg_pkg::CFG_LIFT_THR:     lift_threshold_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input capture with bias and deadband
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      clr_r <= (in_tuser == igtg_pkg::OP_CLEAR);
      rx_r  <= dband(in_tdata[15:0], bias_x_r);
      ry_r  <= dband(in_tdata[31:16], bias_y_r);
      rz_r  <= dband(in_tdata[47:32], bias_z_r);
      ax_r  <= in_tdata[63:48];
      az_r  <= in_tdata[79:64];
    end
  end

  // integrators, filter products, lift test
  logic signed [16:0] az_diff;
  logic [16:0]        az_mag;
  logic signed [17:0] neg_ry;
  logic signed [32:0] acc_err;

  always_comb begin
    az_diff = {az_r[15], az_r} - {prev_az_r[15], prev_az_r};
    az_mag  = az_diff[16] ? (~az_diff + 17'd1) : az_diff;
    neg_ry  = -{ry_r[16], ry_r};
    acc_err = {ax_r[15], ax_r, 16'b0} - {angle_r[31], angle_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_sum_r <= '0;
      roll_sum_r  <= '0;
      yaw_sum_r   <= '0;
      prev_az_r   <= '0;
    end else if (cmd.integ) begin
      if (clr_r) begin
        pitch_sum_r <= '0;
        roll_sum_r  <= '0;
        yaw_sum_r   <= '0;
      end else begin
        pitch_sum_r <= sat_add(pitch_sum_r, ry_r);
        roll_sum_r  <= sat_add(roll_sum_r, rx_r);
        yaw_sum_r   <= sat_add(yaw_sum_r, rz_r);
        prev_az_r   <= az_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.integ) begin
      lift_r <= !clr_r && (az_mag > {1'b0, lift_threshold_r});
      p1_r   <= 27'(neg_ry * $signed({1'b0, rate_weight_r}));
      p2_r   <= 42'(acc_err * $signed({1'b0, accel_weight_r}));
    end
  end

  // filter step product and readout division
  logic signed [43:0] s_sum;

  always_comb begin
    s_sum = ({{17{p1_r[26]}}, p1_r} <<< 16) + {{2{p2_r[41]}}, p2_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= 61'(s_sum * $signed({1'b0, sample_period_r}));
      rd_p_r <= div_pr(pitch_sum_r);
      rd_r_r <= div_pr(roll_sum_r);
      rd_y_r <= div_yaw(yaw_sum_r);
    end
  end

  // angle update, trips, result register
  logic signed [60:0] rnd;
  logic signed [44:0] step;
  logic signed [44:0] ang_sum;
  logic signed [31:0] ang_new;
  logic [31:0]        ang_out;
  logic               tp, tr, ty;
  logic [2:0]         reason;

  always_comb begin
    rnd     = prod_r + 61'sd32768;
    step    = rnd[60:16];
    ang_sum = {{13{angle_r[31]}}, angle_r} + step;
    if (ang_sum > 45'sd2147483647) begin
      ang_new = 32'sh7FFF_FFFF;
    end else if (ang_sum < -45'sd2147483648) begin
      ang_new = 32'sh8000_0000;
    end else begin
      ang_new = ang_sum[31:0];
    end
    ang_out = clr_r ? angle_r : ang_new;
    tp      = mag33(pitch_sum_r) > {2'b0, integral_limit_r};
    tr      = mag33(roll_sum_r) > {2'b0, integral_limit_r};
    ty      = mag33(yaw_sum_r) > {2'b0, integral_limit_r};
    if (ty) begin
      reason = igtg_pkg::RSN_YAW;
    end else if (tr) begin
      reason = igtg_pkg::RSN_ROLL;
    end else if (tp) begin
      reason = igtg_pkg::RSN_PITCH;
    end else if (lift_r) begin
      reason = igtg_pkg::RSN_LIFT;
    end else begin
      reason = igtg_pkg::RSN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
    end else if (cmd.fin) begin
      angle_r <= ang_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_r <= {3'b0, lift_r || ty, reason, reason != igtg_pkg::RSN_NONE, ang_out,
                readout(rd_y_r), readout(rd_r_r), readout(rd_p_r)};
    end
  end

  assign out_tdata = out_r;

endmodule

@@ hw/rtl/imu_gyro_integrate_and_tilt_guard.sv @@
// each accepted input passes the bias, integrate, multiply and finish steps of
//   the shared datapath in turn; a new input is taken only after finish, which
//   waits while the previous result is held with out_tready low
// reset: rst_n synchronous active low; integrators, angle and last accel z
//   clear to zero and the configuration registers take their defaults
module imu_gyro_integrate_and_tilt_guard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // rate_x, rate_y, rate_z, accel_x, accel_z
  input  logic        in_tuser,  // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  // pitch_readout, roll_readout, yaw_readout, tilt_angle, stop_request,
  // stop_reason, show_stop_screen, zero pad
  output logic [87:0] out_tdata
);

  igtg_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  igtg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  igtg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_wr    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule
